// ----- design/crnc_pkg.sv -----
`default_nettype none
package crnc_pkg;

  localparam int unsigned TableDepth = 32;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam int unsigned RatioFracBits = 16;
  localparam int unsigned ValW = 17;
  localparam int unsigned SumW = 19;
  localparam int unsigned ThrW = 19;
  localparam int unsigned MilliW = 10;
  localparam int unsigned DenomW = 20;
  localparam int unsigned BalW = 31;
  localparam int unsigned NoPulsePeriod = 9999;
  localparam int unsigned RawFormLimit = 1000;
  localparam int unsigned MilliDiv = 1000;
  localparam int unsigned ThrReset = 120;
  localparam int unsigned TolReset = 40;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_LOAD   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_SETBAL = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    EV_BACKGROUND = 4'd0,
    EV_RELEASED   = 4'd1,
    EV_WAITING    = 4'd2,
    EV_DETECTED   = 4'd3,
    EV_NO_MATCH   = 4'd4,
    EV_LOADED     = 4'd5,
    EV_FULL       = 4'd6,
    EV_CLEARED    = 4'd7,
    EV_BAL_SET    = 4'd8
  } event_e;

  typedef enum logic [1:0] {
    CFG_CLEAR_THRESHOLD = 2'd0,
    CFG_DEFAULT_TOL     = 2'd1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_INIT,
    ST_DIV_RUN,
    ST_MILLI,
    ST_DIV_DONE,
    ST_WRITE,
    ST_SCAN_RD,
    ST_SCAN_MUL,
    ST_SCAN_CMP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ValW-1:0]   red_value;
    logic [ValW-1:0]   green_value;
    logic [ValW-1:0]   blue_value;
    logic [DenomW-1:0] denomination;
    logic [MilliW-1:0] tolerance_milli;
    logic [BalW-1:0]   balance_value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]        event_res;
    logic [DenomW-1:0] matched_value;
    logic [IdxW-1:0]   matched_index;
    logic [BalW-1:0]   balance;
    logic [CntW-1:0]   entry_count;
  } out_item_t;

endpackage
`default_nettype wire

// ----- design/color_ratio_note_classifier.sv -----
`default_nettype none
// banknote color classifier
// input channel: in_valid_i / in_stall_o carry one operation per transfer
// (sample, load signature, clear table, set balance); output channel:
// out_valid_o / out_stall_i carry exactly one result per accepted item.
// cfg_we_i writes clear_threshold (index 0) or default_tolerance_milli
// (index 1). the user must write only while the block is idle (unchecked).
// clear table, set balance and background or waiting samples go
// straight to the result. a sample that is classified runs three
// restoring divisions, then scans the signature memory entry by entry
// (read, square, compare) until a match or the end of the table. a raw
// load runs three divisions, one reciprocal step for the tolerance and
// one write; a thousandths load uses four reciprocal steps and the
// write. all divisions share the one-bit divider, and the signature
// memory is single-port.
// one item is worked on at a time; the next may be taken while the
// previous result still sits in the output register.
// reset empties the table, clears balance and wait flag and restores the
// register defaults. while the receiver stalls, the result holds in the
// output register and the finished next item waits for it to drain.
module color_ratio_note_classifier #(
  parameter int unsigned RATIO_FRACTION_BITS = crnc_pkg::RatioFracBits
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [0:0]                      cfg_idx_i,
  input  wire logic [crnc_pkg::ThrW-1:0]       cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire crnc_pkg::in_item_t              in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output crnc_pkg::out_item_t                  out_data_o
);
  import crnc_pkg::*;

  localparam int unsigned F   = RATIO_FRACTION_BITS;
  localparam int unsigned NW  = ValW + F + 1;
  localparam int unsigned BW  = $clog2(NW + 1);
  localparam int unsigned EW  = 4 * F + DenomW;
  localparam int unsigned SqW = 2 * F;
  // thousandths to Q0.F: 2^F = 1000*MqA + MqB, remainder part by reciprocal
  localparam int unsigned MqA     = (1 << F) / MilliDiv;
  localparam int unsigned MqB     = (1 << F) % MilliDiv;
  localparam int unsigned MqShift = 30;
  localparam int unsigned MqM     = ((1 << MqShift) + MilliDiv - 1) / MilliDiv;
  localparam int unsigned MqXW    = 20;
  localparam int unsigned MqPW    = MqXW + 21;

  state_e state_q, state_d;
  logic              is_load_q, is_load_d;
  logic [1:0]        k_q, k_d;
  logic [ValW-1:0]   val_q [3];
  logic [ValW-1:0]   val_d [3];
  logic [MilliW-1:0] tnum_q, tnum_d;
  logic [SumW-1:0]   den_q, den_d;
  logic [NW-1:0]     dnum_q, dnum_d;
  logic [SumW-1:0]   rem_q, rem_d;
  logic [BW-1:0]     bcnt_q, bcnt_d;
  logic [F-1:0]      ratio_q [4];
  logic [F-1:0]      ratio_d [4];
  logic [CntW-1:0]   idx_q, idx_d;
  logic [SqW-1:0]    sq_q [3];
  logic [SqW-1:0]    sq_d [3];
  logic [SqW-1:0]    t2_q, t2_d;
  event_e            event_q, event_d;
  logic [DenomW-1:0] mval_q, mval_d;
  logic [DenomW-1:0] dn_q, dn_d;
  logic [BalW-1:0]   bal_q, bal_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              wait_q, wait_d;
  logic [ThrW-1:0]   thr_q;
  logic [MilliW-1:0] dtol_q;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic [EW-1:0]     mem [TableDepth];
  logic [EW-1:0]     rd_q;
  logic              mem_we;
  logic [IdxW-1:0]   mem_addr;
  logic [EW-1:0]     mem_wdata;

  // combinational helpers
  logic [ValW-1:0]   per [3];
  logic [SumW-1:0]   per_sum, raw_sum;
  logic [ValW-1:0]   div_x;
  logic [SumW-1:0]   div_den;
  logic [SumW:0]     trial;
  logic              ge;
  logic              mq_sel;
  logic              mq_big;
  logic [MilliW-1:0] mq_v;
  logic [MqXW-1:0]   mq_x;
  logic [MqPW-1:0]   mq_prod;
  logic [NW-1:0]     mq_q;
  logic [F-1:0]      ent_c [3];
  logic [F-1:0]      ent_tol;
  logic [F-1:0]      diff [3];
  logic [SqW+1:0]    d2;
  logic [BalW:0]     bal_sum;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      per[i] = '0;
    end
    per[0] = (in_data_i.red_value == '0) ? ValW'(NoPulsePeriod) : in_data_i.red_value;
    per[1] = (in_data_i.green_value == '0) ? ValW'(NoPulsePeriod) : in_data_i.green_value;
    per[2] = (in_data_i.blue_value == '0) ? ValW'(NoPulsePeriod) : in_data_i.blue_value;
    per_sum = SumW'(per[0]) + SumW'(per[1]) + SumW'(per[2]);
    raw_sum = SumW'(in_data_i.red_value) + SumW'(in_data_i.green_value)
            + SumW'(in_data_i.blue_value);
  end

  always_comb begin
    div_x   = (k_q == 2'd3) ? ValW'(tnum_q) : val_q[k_q];
    div_den = den_q;
    trial   = {rem_q, dnum_q[NW-1]};
    ge      = (trial >= {1'b0, div_den});
  end

  // thousandths path: tolerance always, components on a scaled load
  always_comb begin
    mq_sel  = (k_q == 2'd3) || (is_load_q && den_q == SumW'(MilliDiv));
    mq_big  = (div_x >= ValW'(MilliDiv));
    mq_v    = div_x[MilliW-1:0];
    mq_x    = MqXW'(mq_v) * MqXW'(MqB) + MqXW'(MilliDiv / 2);
    mq_prod = MqPW'(dnum_q[MqXW-1:0]) * MqPW'(MqM);
    mq_q    = NW'(mq_v) * NW'(MqA) + NW'(mq_prod[MqPW-1:MqShift]);
  end

  always_comb begin
    ent_c[0] = rd_q[4*F+DenomW-1 -: F];
    ent_c[1] = rd_q[3*F+DenomW-1 -: F];
    ent_c[2] = rd_q[2*F+DenomW-1 -: F];
    ent_tol  = rd_q[F+DenomW-1 -: F];
    for (int i = 0; i < 3; i++) begin
      diff[i] = (ratio_q[i] > ent_c[i]) ? ratio_q[i] - ent_c[i] : ent_c[i] - ratio_q[i];
    end
    d2 = (SqW+2)'(sq_q[0]) + (SqW+2)'(sq_q[1]) + (SqW+2)'(sq_q[2]);
    bal_sum = (BalW+1)'(bal_q) + (BalW+1)'(rd_q[DenomW-1:0]);
  end

  always_comb begin
    state_d   = state_q;
    is_load_d = is_load_q;
    k_d       = k_q;
    val_d     = val_q;
    tnum_d    = tnum_q;
    den_d     = den_q;
    dnum_d    = dnum_q;
    rem_d     = rem_q;
    bcnt_d    = bcnt_q;
    ratio_d   = ratio_q;
    idx_d     = idx_q;
    sq_d      = sq_q;
    t2_d      = t2_q;
    event_d   = event_q;
    mval_d    = mval_q;
    dn_d      = dn_q;
    bal_d     = bal_q;
    cnt_d     = cnt_q;
    wait_d    = wait_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d     = out_q;
    mem_we    = 1'b0;
    mem_addr  = idx_q[IdxW-1:0];
    mem_wdata = {ratio_q[0], ratio_q[1], ratio_q[2], ratio_q[3], dn_q};

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mval_d = '0;
          idx_d  = '0;
          k_d    = '0;
          dn_d   = in_data_i.denomination;
          case (in_data_i.operation)
            OP_SAMPLE: begin
              is_load_d = 1'b0;
              val_d     = per;
              den_d     = per_sum;
              if (per_sum < thr_q) begin
                event_d = wait_q ? EV_RELEASED : EV_BACKGROUND;
                wait_d  = 1'b0;
                state_d = ST_DONE;
              end else if (wait_q) begin
                event_d = EV_WAITING;
                state_d = ST_DONE;
              end else begin
                state_d = ST_DIV_INIT;
              end
            end
            OP_LOAD: begin
              is_load_d = 1'b1;
              val_d[0]  = in_data_i.red_value;
              val_d[1]  = in_data_i.green_value;
              val_d[2]  = in_data_i.blue_value;
              if (cnt_q >= CntW'(TableDepth)) begin
                event_d = EV_FULL;
                state_d = ST_DONE;
              end else if (in_data_i.red_value > ValW'(RawFormLimit)) begin
                den_d   = raw_sum;
                tnum_d  = dtol_q;
                state_d = ST_DIV_INIT;
              end else begin
                den_d   = SumW'(MilliDiv);
                tnum_d  = (in_data_i.tolerance_milli != '0) ? in_data_i.tolerance_milli
                                                            : dtol_q;
                state_d = ST_DIV_INIT;
              end
            end
            OP_CLEAR: begin
              cnt_d   = '0;
              event_d = EV_CLEARED;
              state_d = ST_DONE;
            end
            default: begin
              bal_d   = in_data_i.balance_value;
              event_d = EV_BAL_SET;
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_DIV_INIT: begin
        if (mq_sel) begin
          dnum_d  = NW'(mq_x);
          state_d = ST_MILLI;
        end else begin
          // rounded quotient: (x * 2^F + den/2) / den
          dnum_d  = NW'({div_x, {F{1'b0}}}) + NW'(div_den >> 1);
          rem_d   = '0;
          bcnt_d  = '0;
          state_d = ST_DIV_RUN;
        end
      end
      ST_DIV_RUN: begin
        rem_d  = ge ? SumW'(trial - {1'b0, div_den}) : trial[SumW-1:0];
        dnum_d = {dnum_q[NW-2:0], ge};
        bcnt_d = bcnt_q + 1'b1;
        if (bcnt_q == BW'(NW - 1)) begin
          state_d = ST_DIV_DONE;
        end
      end
      ST_MILLI: begin
        // a thousand thousandths or more is 1.0, saturated below
        dnum_d  = mq_big ? {NW{1'b1}} : mq_q;
        state_d = ST_DIV_DONE;
      end
      ST_DIV_DONE: begin
        ratio_d[k_q] = (dnum_q[NW-1:F] != '0) ? {F{1'b1}} : dnum_q[F-1:0];
        k_d = k_q + 1'b1;
        if (is_load_q && k_q == 2'd3) begin
          state_d = ST_WRITE;
        end else if (!is_load_q && k_q == 2'd2) begin
          state_d = ST_SCAN_RD;
        end else begin
          state_d = ST_DIV_INIT;
        end
      end
      ST_WRITE: begin
        mem_we   = 1'b1;
        mem_addr = cnt_q[IdxW-1:0];
        idx_d    = cnt_q;
        cnt_d    = cnt_q + 1'b1;
        event_d  = EV_LOADED;
        state_d  = ST_DONE;
      end
      ST_SCAN_RD: begin
        if (idx_q == cnt_q) begin
          event_d = EV_NO_MATCH;
          idx_d   = '0;
          state_d = ST_DONE;
        end else begin
          state_d = ST_SCAN_MUL;
        end
      end
      ST_SCAN_MUL: begin
        for (int i = 0; i < 3; i++) begin
          sq_d[i] = SqW'(diff[i]) * SqW'(diff[i]);
        end
        t2_d    = SqW'(ent_tol) * SqW'(ent_tol);
        state_d = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (d2 < (SqW+2)'(t2_q)) begin
          bal_d   = bal_sum[BalW] ? {BalW{1'b1}} : bal_sum[BalW-1:0];
          wait_d  = 1'b1;
          event_d = EV_DETECTED;
          mval_d  = rd_q[DenomW-1:0];
          state_d = ST_DONE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_SCAN_RD;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d         = 1'b1;
          out_d.event_res     = event_q;
          out_d.matched_value = mval_q;
          out_d.matched_index = idx_q[IdxW-1:0];
          out_d.balance       = bal_q;
          out_d.entry_count   = cnt_q;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_q <= mem[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bal_q       <= '0;
      cnt_q       <= '0;
      wait_q      <= 1'b0;
      thr_q       <= ThrW'(ThrReset);
      dtol_q      <= MilliW'(TolReset);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bal_q       <= bal_d;
      cnt_q       <= cnt_d;
      wait_q      <= wait_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == 1'(CFG_CLEAR_THRESHOLD)) begin
          thr_q <= cfg_data_i;
        end else begin
          dtol_q <= cfg_data_i[MilliW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    is_load_q <= is_load_d;
    k_q       <= k_d;
    val_q     <= val_d;
    tnum_q    <= tnum_d;
    den_q     <= den_d;
    dnum_q    <= dnum_d;
    rem_q     <= rem_d;
    bcnt_q    <= bcnt_d;
    ratio_q   <= ratio_d;
    idx_q     <= idx_d;
    sq_q      <= sq_d;
    t2_q      <= t2_d;
    event_q   <= event_d;
    mval_q    <= mval_d;
    dn_q      <= dn_d;
    out_q     <= out_d;
  end

endmodule
`default_nettype wire
